[rtl/core/slam_pkg.sv]
`timescale 1ns / 1ps

package slam_pkg;

  localparam int unsigned BoardW  = 64;
  localparam int unsigned SquareW = 6;
  localparam int unsigned ModeW   = 2;

  typedef enum logic [ModeW-1:0] {
    MODE_DIAG = 2'd0,
    MODE_ANTI = 2'd1,
    MODE_FILE = 2'd2,
    MODE_RANK = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    DIR_N  = 3'd0,
    DIR_NE = 3'd1,
    DIR_E  = 3'd2,
    DIR_SE = 3'd3,
    DIR_S  = 3'd4,
    DIR_SW = 3'd5,
    DIR_W  = 3'd6,
    DIR_NW = 3'd7
  } dir_e;

  // The two rays of one line: up runs toward higher square indexes.
  typedef struct packed {
    logic [BoardW-1:0] up;
    logic [BoardW-1:0] dn;
  } ray_pair_t;

  // Squares on the ray from sq in direction dir, origin excluded, stopping at the edge.
  function automatic logic [BoardW-1:0] ray_mask(input dir_e dir,
                                                 input logic [SquareW-1:0] sq);
    int dr;
    int df;
    int r;
    int f;
    logic [BoardW-1:0] m;
    case (dir)
      DIR_N:   begin dr =  1; df =  0; end
      DIR_NE:  begin dr =  1; df =  1; end
      DIR_E:   begin dr =  0; df =  1; end
      DIR_SE:  begin dr = -1; df =  1; end
      DIR_S:   begin dr = -1; df =  0; end
      DIR_SW:  begin dr = -1; df = -1; end
      DIR_W:   begin dr =  0; df = -1; end
      default: begin dr =  1; df = -1; end
    endcase
    m = '0;
    for (int k = 1; k < 8; k++) begin
      r = int'(sq[5:3]) + k * dr;
      f = int'(sq[2:0]) + k * df;
      if (r >= 0 && r < 8 && f >= 0 && f < 8) begin
        m[SquareW'(r * 8 + f)] = 1'b1;
      end
    end
    return m;
  endfunction

endpackage

[rtl/core/slam_ray_gen.sv]
`timescale 1ns / 1ps

module slam_ray_gen (
  input  logic [slam_pkg::SquareW-1:0] square_i,
  input  logic [slam_pkg::ModeW-1:0]   mode_i,
  output slam_pkg::ray_pair_t          rays_o
);
  import slam_pkg::*;

  // Each mode pairs a ray toward higher indexes with its opposite.
  always_comb begin
    case (mode_e'(mode_i))
      MODE_DIAG: begin
        rays_o.up = ray_mask(DIR_NE, square_i);
        rays_o.dn = ray_mask(DIR_SW, square_i);
      end
      MODE_ANTI: begin
        rays_o.up = ray_mask(DIR_NW, square_i);
        rays_o.dn = ray_mask(DIR_SE, square_i);
      end
      MODE_FILE: begin
        rays_o.up = ray_mask(DIR_N, square_i);
        rays_o.dn = ray_mask(DIR_S, square_i);
      end
      default: begin
        rays_o.up = ray_mask(DIR_E, square_i);
        rays_o.dn = ray_mask(DIR_W, square_i);
      end
    endcase
  end

endmodule

[rtl/core/sliding_line_attack_mask.sv]
`timescale 1ns / 1ps

// Channel  | Direction | Handshake                 | Payload
// ---------+-----------+---------------------------+---------------------------------
// query    | in        | in_valid_i / in_ready_o   | occupancy_i, square_i, mode_i
// result   | out       | out_valid_o / out_ready_i | attacks_o
//
// One query is taken per cycle while the output is not stalled. Its result passes through
// the stage 1, stage 2 and output registers in turn before out_valid_o rises for it.
// The three register stages are ray lookup, blocker search and ray cut; the last one is
// the output register. Reset clears only the stage valid bits; the block has no other state.
// A stalled output stage holds its result, and an earlier stage keeps its item until the
// stage after it has room, so in_ready_o stays high while any stage holds a bubble.

module sliding_line_attack_mask (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [slam_pkg::BoardW-1:0]   occupancy_i,
  input  logic [slam_pkg::SquareW-1:0]  square_i,
  input  logic [slam_pkg::ModeW-1:0]    mode_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [slam_pkg::BoardW-1:0]   attacks_o
);
  import slam_pkg::*;

  // Stage enables: a stage loads when it is empty or its item moves on.
  logic en1, en2, en3;

  // Stage 1: the two ray masks of the chosen line, plus the occupancy.
  ray_pair_t         rays_d;
  ray_pair_t         s1_rays_q;
  logic [BoardW-1:0] s1_occ_q;
  logic              s1_valid_q;

  // Stage 2: rays and the masks that keep each ray up to its nearest blocker.
  ray_pair_t         s2_rays_q;
  logic [BoardW-1:0] s2_keep_up_d, s2_keep_up_q;
  logic [BoardW-1:0] s2_keep_dn_d, s2_keep_dn_q;
  logic              s2_valid_q;

  // Stage 3: the output register.
  logic [BoardW-1:0] attacks_d, attacks_q;
  logic              s3_valid_q;

  logic [BoardW-1:0] blk_up, blk_dn, smear_dn;

  assign en3        = !s3_valid_q || out_ready_i;
  assign en2        = !s2_valid_q || en3;
  assign en1        = !s1_valid_q || en2;
  assign in_ready_o = en1;

  slam_ray_gen u_ray_gen (
    .square_i (square_i),
    .mode_i   (mode_i),
    .rays_o   (rays_d)
  );

  // The upward ray ends at the lowest blocker: blk ^ (blk - 1) sets every bit up to
  // and including it, and is all ones when there is no blocker. The downward ray ends
  // at the highest blocker: smearing it downward and shifting by one marks the squares
  // below it, and is zero when there is no blocker.
  always_comb begin
    blk_up       = s1_rays_q.up & s1_occ_q;
    blk_dn       = s1_rays_q.dn & s1_occ_q;
    s2_keep_up_d = blk_up ^ (blk_up - BoardW'(1));
    smear_dn     = blk_dn;
    smear_dn     = smear_dn | (smear_dn >> 1);
    smear_dn     = smear_dn | (smear_dn >> 2);
    smear_dn     = smear_dn | (smear_dn >> 4);
    smear_dn     = smear_dn | (smear_dn >> 8);
    smear_dn     = smear_dn | (smear_dn >> 16);
    smear_dn     = smear_dn | (smear_dn >> 32);
    s2_keep_dn_d = ~(smear_dn >> 1);
  end

  assign attacks_d = (s2_rays_q.up & s2_keep_up_q) | (s2_rays_q.dn & s2_keep_dn_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      if (en1) s1_valid_q <= in_valid_i;
      if (en2) s2_valid_q <= s1_valid_q;
      if (en3) s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      s1_rays_q <= rays_d;
      s1_occ_q  <= occupancy_i;
    end
    if (en2) begin
      s2_rays_q    <= s1_rays_q;
      s2_keep_up_q <= s2_keep_up_d;
      s2_keep_dn_q <= s2_keep_dn_d;
    end
    if (en3) begin
      attacks_q <= attacks_d;
    end
  end

  assign out_valid_o = s3_valid_q;
  assign attacks_o   = attacks_q;

  // The two rays of a line never share a square.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |-> ((s1_rays_q.up & s1_rays_q.dn) == '0))
    else $error("rays of one line overlap");

  // The upward keep mask is a run of ones starting at bit zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_valid_q |-> ((s2_keep_up_q & (s2_keep_up_q + BoardW'(1))) == '0))
    else $error("upward keep mask is not a low run of ones");

  // A result only holds squares that lie on the line's rays.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_valid_q && en3) |=>
      ((attacks_q & ~($past(s2_rays_q.up) | $past(s2_rays_q.dn))) == '0))
    else $error("result has a square off the line");

  // With every stage full and the output stalled, no query may be taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s2_valid_q && s3_valid_q && !out_ready_i) |-> !in_ready_o)
    else $error("query taken into a full pipeline");

endmodule
